>>> design/looz_pkg.sv
// ----------------------------------------------------------------------------
// looz_pkg
// Shared constants, types and helpers of the leave-one-out z-score block.
// ----------------------------------------------------------------------------
package looz_pkg;

    localparam int MaxMembers = 128;
    localparam int MemAw      = $clog2(MaxMembers);
    localparam int SizeW      = 8;
    localparam int PcW        = 21;
    localparam int QDepth     = 4;
    localparam int QAw        = $clog2(QDepth);

    typedef enum logic [1:0] {
        REG_SIZE = 2'd0,
        REG_EXCL = 2'd1,
        REG_THR  = 2'd2,
        REG_PCNT = 2'd3
    } t_reg;

    // queue entry: one sample, its store slot, and a flag that it closes the point
    typedef struct packed {
        logic [31:0]      sample;
        logic [MemAw-1:0] slot;
        logic             close;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_DIV1, ST_VAR, ST_MUL, ST_ACC, ST_VDIV,
        ST_SQRT, ST_ZDIV, ST_DONE
    } t_state;

    function automatic logic [SizeW-1:0] eff_size(input logic [7:0] s);
        logic [SizeW-1:0] r;
        r = s;
        if (s < 8'd3) r = 8'd3;
        if ({1'b0, s} > 9'(MaxMembers)) r = SizeW'(MaxMembers);
        return r;
    endfunction

endpackage

>>> design/looz_front.sv
// ----------------------------------------------------------------------------
// looz_front
// Counts members of a point and pushes each sample with its store slot into
// the queue; marks the sample that completes a point.
// ----------------------------------------------------------------------------
module looz_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_size,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [31:0]             i_sample,
    output logic                    o_push,
    output looz_pkg::t_entry        o_entry,
    input  logic                    i_full
);
    logic [looz_pkg::SizeW-1:0] r_cnt, n_cnt, w_size, w_idx;

    assign w_size  = looz_pkg::eff_size(i_size);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_idx   = (r_cnt >= w_size) ? w_size - 1'b1 : r_cnt;

    always_comb begin
        o_entry.sample = i_sample;
        o_entry.slot   = w_idx[looz_pkg::MemAw-1:0];
        o_entry.close  = (w_idx + 1'b1) >= w_size;
        n_cnt          = o_entry.close ? '0 : w_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> design/looz_queue.sv
// ----------------------------------------------------------------------------
// looz_queue
// Short FIFO between the front end and the compute back end.
// ----------------------------------------------------------------------------
module looz_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  looz_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output looz_pkg::t_entry o_entry
);
    looz_pkg::t_entry r_mem [looz_pkg::QDepth];
    logic [looz_pkg::QAw-1:0] r_wp, r_rp;
    logic [looz_pkg::QAw:0]   r_cnt;

    assign o_full  = r_cnt == (looz_pkg::QAw+1)'(looz_pkg::QDepth);
    assign o_empty = r_cnt == '0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (looz_pkg::QAw+1)'(i_push) - (looz_pkg::QAw+1)'(i_pop);
        end
    end

endmodule

>>> design/looz_back.sv
// ----------------------------------------------------------------------------
// looz_back
// Stores samples, and on a closing sample runs the per-point statistics:
// sum, mean divide, squared deviations, variance divide, square root and
// the final z divide, then holds the result in an output register.
// ----------------------------------------------------------------------------
module looz_back (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_size,
    input  logic [6:0]  i_excl,
    input  logic [31:0] i_thr,
    input  logic [20:0] i_pcnt,
    input  logic        i_empty,
    input  looz_pkg::t_entry i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_z,
    output logic        o_flat,
    output logic        o_sat,
    output logic        o_last
);
    localparam int Aw = looz_pkg::MemAw;

    looz_pkg::t_state r_st, n_st;
    logic [31:0]  r_mem [looz_pkg::MaxMembers];
    logic [31:0]  r_rd;
    logic [Aw:0]  r_j;
    logic [Aw-1:0] w_ex;
    logic [7:0]   w_size, w_n;
    logic signed [39:0] r_sum;
    logic signed [39:0] w_sum_nx;
    logic         w_incl;
    logic signed [32:0] r_mean;
    logic signed [32:0] r_xex;
    logic signed [32:0] r_d;
    logic [65:0]  r_sq;
    logic [72:0]  r_acc;
    // shared restoring divider
    logic [72:0]  r_quo;
    logic [63:0]  r_den;
    logic [64:0]  r_rem;
    logic [6:0]   r_it;
    logic         r_neg;
    logic [63:0]  r_var;
    logic [31:0]  r_sd;
    logic [65:0]  r_srem;
    logic [5:0]   r_si;
    logic [20:0]  r_pc;
    logic         r_rdv;
    logic         w_last;
    logic [64:0]  w_trial;
    logic [65:0]  w_strial;
    logic [65:0]  w_srem_sh;

    assign w_size = looz_pkg::eff_size(i_size);
    assign w_n    = w_size - 8'd1;
    assign w_ex   = ({1'b0, i_excl} >= w_size) ? w_n[Aw-1:0] : i_excl[Aw-1:0];
    assign w_last = (r_pc + 21'd1) >= ((i_pcnt == '0) ? 21'd1 : i_pcnt);
    assign w_trial = {r_rem[63:0], r_quo[72]} - {1'b0, r_den};
    assign w_srem_sh = {r_srem[63:0], r_var[63:62]};
    assign w_strial = w_srem_sh - {32'd0, r_sd, 2'b01};
    assign w_incl   = r_rdv && (r_j - 1'b1 != (Aw+1)'(w_ex));
    assign w_sum_nx = w_incl ? r_sum + 40'(signed'(r_rd)) : r_sum;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            looz_pkg::ST_IDLE: if (!i_empty && i_entry.close) n_st = looz_pkg::ST_SUM;
            looz_pkg::ST_SUM:  if (r_rdv && r_j == (Aw+1)'(w_size)) n_st = looz_pkg::ST_DIV1;
            looz_pkg::ST_DIV1: if (r_it == '0) n_st = looz_pkg::ST_VAR;
            looz_pkg::ST_VAR:  n_st = looz_pkg::ST_MUL;
            looz_pkg::ST_MUL:  n_st = looz_pkg::ST_ACC;
            looz_pkg::ST_ACC:  n_st = (r_j == (Aw+1)'(w_size)) ? looz_pkg::ST_VDIV
                                    : looz_pkg::ST_VAR;
            looz_pkg::ST_VDIV: if (r_it == '0) n_st = looz_pkg::ST_SQRT;
            looz_pkg::ST_SQRT: if (r_si == '0) n_st = looz_pkg::ST_ZDIV;
            looz_pkg::ST_ZDIV: if (r_it == '0 || r_sd <= i_thr) n_st = looz_pkg::ST_DONE;
            looz_pkg::ST_DONE: if (!o_valid) n_st = looz_pkg::ST_IDLE;
            default:           n_st = looz_pkg::ST_IDLE;
        endcase
    end

    assign o_pop = !i_empty && r_st == looz_pkg::ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_mem[i_entry.slot] <= i_entry.sample;
        r_rd <= r_mem[r_j[Aw-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= looz_pkg::ST_IDLE;
            o_valid <= 1'b0;
            r_pc <= '0;
            r_rdv <= 1'b0;
            r_j <= '0;
        end else begin
            r_st <= n_st;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                looz_pkg::ST_IDLE: begin
                    r_j <= '0; r_rdv <= 1'b0; r_sum <= '0;
                end
                looz_pkg::ST_SUM: begin
                    // r_rd holds entry r_j-1
                    if (r_rdv) begin
                        if (w_incl) r_sum <= w_sum_nx;
                        else r_xex <= 33'(signed'(r_rd));
                    end
                    if (n_st == looz_pkg::ST_DIV1) begin
                        r_neg <= w_sum_nx[39];
                        r_quo <= 73'(w_sum_nx[39] ? -w_sum_nx : w_sum_nx) << 33;
                        r_den <= 64'(w_n);
                        r_rem <= '0;
                        r_it  <= 7'd40;
                        r_j <= '0; r_rdv <= 1'b0; r_acc <= '0;
                    end else begin
                        r_rdv <= 1'b1;
                        r_j <= r_j + 1'b1;
                    end
                end
                looz_pkg::ST_DIV1, looz_pkg::ST_VDIV, looz_pkg::ST_ZDIV: begin
                    if (r_it != '0) begin
                        r_it <= r_it - 1'b1;
                        r_quo <= {r_quo[71:0], !w_trial[64]};
                        r_rem <= w_trial[64] ? {r_rem[63:0], r_quo[72]} : w_trial;
                    end
                    if (r_st == looz_pkg::ST_DIV1 && r_it == '0)
                        r_mean <= r_neg ? -33'(r_quo[32:0]) : 33'(r_quo[32:0]);
                    if (r_st == looz_pkg::ST_VDIV && r_it == '0) begin
                        r_var <= r_quo[63:0]; r_sd <= '0; r_srem <= '0; r_si <= 6'd32;
                    end
                end
                looz_pkg::ST_VAR: begin
                    // r_rd holds entry r_j
                    if (r_j == (Aw+1)'(w_ex)) r_d <= '0;
                    else r_d <= 33'(signed'(r_rd)) - r_mean;
                    r_j <= r_j + 1'b1;
                end
                looz_pkg::ST_MUL: begin
                    r_sq <= 66'($signed(r_d) * $signed(r_d));
                end
                looz_pkg::ST_ACC: begin
                    r_acc <= r_acc + 73'(r_sq);
                    if (n_st == looz_pkg::ST_VDIV) begin
                        r_quo <= r_acc + 73'(r_sq); r_den <= 64'(w_n); r_rem <= '0;
                        r_it <= 7'd73;
                    end
                end
                looz_pkg::ST_SQRT: begin
                    if (r_si != '0) begin
                        r_si <= r_si - 1'b1;
                        r_var <= {r_var[61:0], 2'b00};
                        if (!w_strial[65]) begin
                            r_srem <= w_strial; r_sd <= {r_sd[30:0], 1'b1};
                        end else begin
                            r_srem <= w_srem_sh; r_sd <= {r_sd[30:0], 1'b0};
                        end
                    end
                    if (r_si == 6'd1) begin
                        r_d <= r_xex - r_mean;
                    end
                end
                default: ;
            endcase
            if (r_st == looz_pkg::ST_SQRT && r_si == '0) begin
                r_neg <= r_d[32];
                r_den <= 64'(r_sd); r_rem <= '0; r_it <= 7'd49;
                r_quo <= 73'({(r_d[32] ? 33'(-r_d) : r_d), 16'd0}) << 24;
            end
            if (r_st == looz_pkg::ST_ZDIV && n_st == looz_pkg::ST_DONE) begin
                o_valid <= 1'b1;
                o_last <= w_last;
                r_pc <= w_last ? '0 : r_pc + 21'd1;
                if (r_sd <= i_thr) begin
                    o_flat <= 1'b1; o_sat <= 1'b0; o_z <= '0;
                end else begin
                    o_flat <= 1'b0;
                    if (!r_neg && r_quo[48:0] > 49'h7FFFFFFF) begin
                        o_z <= 32'h7FFFFFFF; o_sat <= 1'b1;
                    end else if (r_neg && r_quo[48:0] > 49'h80000000) begin
                        o_z <= 32'h80000000; o_sat <= 1'b1;
                    end else begin
                        o_z <= r_neg ? -r_quo[31:0] : r_quo[31:0]; o_sat <= 1'b0;
                    end
                end
            end
        end
    end

    a_flat_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flat |-> !o_sat && o_z == '0) else $error("flat with z");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_z)) else $error("result lost");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == looz_pkg::ST_IDLE) else $error("pop while busy");

endmodule

>>> design/leave_one_out_zscore.sv
// ----------------------------------------------------------------------------
// leave_one_out_zscore
// Leave-one-out z score of one ensemble member per grid point.
// ----------------------------------------------------------------------------
// Samples enter one per cycle, while the queue has room, into a four-deep
// queue and are written to the member store. The last member of a point
// starts the compute pass: sum pass at one member per cycle, 40-step mean
// divide, multiply-accumulate pass through the VAR, MUL and ACC states per
// member, 73-step variance divide, 32-step square root and 49-step z divide;
// sampling stalls once the queue fills behind a closing sample. Result on
// m_axis, last point in tlast.
module leave_one_out_zscore (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // z_score
    output logic [1:0]  m_axis_tuser,   // flat, saturated
    output logic        m_axis_tlast
);
    logic [7:0]  r_size;
    logic [6:0]  r_excl;
    logic [31:0] r_thr;
    logic [20:0] r_pcnt;
    logic w_push, w_full, w_pop, w_empty;
    looz_pkg::t_entry w_in, w_out;
    looz_pkg::t_reg w_reg;

    assign pready = 1'b1;
    assign w_reg  = looz_pkg::t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 8'd101; r_excl <= '0; r_thr <= '0; r_pcnt <= 21'd48602;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                looz_pkg::REG_SIZE: r_size <= pwdata[7:0];
                looz_pkg::REG_EXCL: r_excl <= pwdata[6:0];
                looz_pkg::REG_THR:  r_thr  <= pwdata;
                looz_pkg::REG_PCNT: r_pcnt <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            looz_pkg::REG_SIZE: prdata = {24'd0, r_size};
            looz_pkg::REG_EXCL: prdata = {25'd0, r_excl};
            looz_pkg::REG_THR:  prdata = r_thr;
            looz_pkg::REG_PCNT: prdata = {11'd0, r_pcnt};
            default:            prdata = '0;
        endcase
    end

    looz_front u_front (.i_clk, .i_rst_n, .i_size(r_size), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_sample(s_axis_tdata), .o_push(w_push),
        .o_entry(w_in), .i_full(w_full));

    looz_queue u_queue (.i_clk, .i_rst_n, .i_push(w_push), .i_entry(w_in),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_entry(w_out));

    looz_back u_back (.i_clk, .i_rst_n, .i_size(r_size), .i_excl(r_excl),
        .i_thr(r_thr), .i_pcnt(r_pcnt), .i_empty(w_empty), .i_entry(w_out),
        .o_pop(w_pop), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_z(m_axis_tdata), .o_flat(m_axis_tuser[0]), .o_sat(m_axis_tuser[1]),
        .o_last(m_axis_tlast));

endmodule
